// File: rtl/rso_pkg.sv
// Package: shared operation codes and lane types for the rectangle overlap tester.
`timescale 1ns / 1ps
package rso_pkg;
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_POINT = 2'd1,
        OP_RECT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Per-axis lane results handed to the merge stage.
    typedef struct packed {
        logic pt_in;
        logic ov;
    } t_lane_res;
endpackage

// File: rtl/rso_lane.sv
// Module: one axis lane, projects corners on an axis and checks the intervals.
`timescale 1ns / 1ps
module rso_lane #(
    parameter int CW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [CW-1:0]       i_ax0_x,
    input  logic signed [CW-1:0]       i_ax0_y,
    input  logic signed [CW-1:0]       i_ax1_x,
    input  logic signed [CW-1:0]       i_ax1_y,
    input  logic signed [4*CW-1:0]     i_ox,
    input  logic signed [4*CW-1:0]     i_oy,
    output rso_pkg::t_lane_res         o_res
);
    import rso_pkg::*;
    localparam int AW = CW + 1;
    localparam int PW = 2 * AW + 1;

    logic signed [AW-1:0] w_ax, w_ay;
    logic signed [PW-1:0] r_p0, r_p1, r_q [4];
    logic signed [PW-1:0] w_alo, w_ahi, w_blo, w_bhi, w_m0, w_m1, w_x0, w_x1;

    assign w_ax = AW'(i_ax1_x) - AW'(i_ax0_x);
    assign w_ay = AW'(i_ax1_y) - AW'(i_ax0_y);

    // Stage 1: projections, one multiply pair per corner.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= PW'(w_ax * PW'(i_ax0_x)) + PW'(w_ay * PW'(i_ax0_y));
            r_p1 <= PW'(w_ax * PW'(i_ax1_x)) + PW'(w_ay * PW'(i_ax1_y));
            for (int j = 0; j < 4; j++) begin
                r_q[j] <= PW'(w_ax * PW'($signed(i_ox[j*CW +: CW])))
                        + PW'(w_ay * PW'($signed(i_oy[j*CW +: CW])));
            end
        end
    end

    // Stage 2 logic: sort own span, min/max other span, compare.
    always_comb begin
        w_alo = (r_p1 < r_p0) ? r_p1 : r_p0;
        w_ahi = (r_p1 < r_p0) ? r_p0 : r_p1;
        w_m0  = (r_q[1] < r_q[0]) ? r_q[1] : r_q[0];
        w_x0  = (r_q[1] < r_q[0]) ? r_q[0] : r_q[1];
        w_m1  = (r_q[3] < r_q[2]) ? r_q[3] : r_q[2];
        w_x1  = (r_q[3] < r_q[2]) ? r_q[2] : r_q[3];
        w_blo = (w_m1 < w_m0) ? w_m1 : w_m0;
        w_bhi = (w_x0 < w_x1) ? w_x1 : w_x0;
        o_res.pt_in = !(r_q[0] < w_alo) && !(w_ahi < r_q[0]);
        o_res.ov    = (w_alo < w_blo) ? (w_blo < w_ahi) : (w_alo < w_bhi);
    end
endmodule

// File: rtl/rso_merge.sv
// Module: merges lane results (4 for a rectangle, 2 for a point) into one registered hit.
`timescale 1ns / 1ps
module rso_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic                  i_pt,
    input  rso_pkg::t_lane_res    i_res [4],
    input  logic                  i_rdy,
    output logic                  o_vld,
    output logic                  o_hit
);
    import rso_pkg::*;
    logic r_vld, r_hit;
    logic n_hit;

    always_comb begin
        if (i_pt) n_hit = i_res[0].pt_in & i_res[1].pt_in;
        else      n_hit = i_res[0].ov & i_res[1].ov & i_res[2].ov & i_res[3].ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_vld) begin
            r_vld <= 1'b1;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) r_hit <= n_hit;
    end

    assign o_vld = r_vld;
    assign o_hit = r_hit;
endmodule

// File: rtl/rect_sat_overlap_test_core.sv
// Module: top level of the oriented-rectangle overlap tester.
//   channel | direction | handshake           | payload
//   input   | in        | i_valid / o_ready   | i_operation, i_corner0_x .. i_corner3_y
//   result  | out       | o_valid / i_ready   | o_hit
// One transaction per cycle unless the output stalls. Stage 1 registers the projections
// (one multiply pair per corner in four axis lanes); stage 2 sorts, compares and merges.
// A load updates the stored corners at once, so the next point can follow directly.
// Reset clears the stored corners to zero and empties the pipe.
// The whole pipe advances only when the output register is free or being drained.
`timescale 1ns / 1ps
module rect_sat_overlap_test_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner3_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner3_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit
);
    import rso_pkg::*;
    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0] r_ex [4];
    logic signed [CW-1:0] r_ey [4];
    logic                 r_s1_vld, r_s1_pt;
    logic                 w_adv, w_acc, w_test;
    logic [4*CW-1:0]      w_ix, w_iy, w_ex, w_ey;
    t_lane_res            w_res [4];

    // Advance when the output slot is empty or drains this cycle.
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && o_ready;
    assign w_test  = w_acc && (t_op'(i_operation) == OP_POINT || t_op'(i_operation) == OP_RECT);

    assign w_ix = {i_corner3_x, i_corner2_x, i_corner1_x, i_corner0_x};
    assign w_iy = {i_corner3_y, i_corner2_y, i_corner1_y, i_corner0_y};
    assign w_ex = {r_ex[3], r_ex[2], r_ex[1], r_ex[0]};
    assign w_ey = {r_ey[3], r_ey[2], r_ey[1], r_ey[0]};

    // Hold the element rectangle; a load transaction replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_ex[j] <= '0;
                r_ey[j] <= '0;
            end
        end else if (w_acc && t_op'(i_operation) == OP_LOAD) begin
            r_ex[0] <= i_corner0_x; r_ey[0] <= i_corner0_y;
            r_ex[1] <= i_corner1_x; r_ey[1] <= i_corner1_y;
            r_ex[2] <= i_corner2_x; r_ey[2] <= i_corner2_y;
            r_ex[3] <= i_corner3_x; r_ey[3] <= i_corner3_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_test;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_s1_pt <= (t_op'(i_operation) == OP_POINT);
    end

    // Lanes 0,1: element axes against input corners (lane 0 q[0] is the point).
    rso_lane #(.CW(CW)) u_lane0 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_ax0_x(r_ex[0]), .i_ax0_y(r_ey[0]), .i_ax1_x(r_ex[1]), .i_ax1_y(r_ey[1]),
        .i_ox(w_ix), .i_oy(w_iy), .o_res(w_res[0]));
    rso_lane #(.CW(CW)) u_lane1 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_ax0_x(r_ex[0]), .i_ax0_y(r_ey[0]), .i_ax1_x(r_ex[2]), .i_ax1_y(r_ey[2]),
        .i_ox(w_ix), .i_oy(w_iy), .o_res(w_res[1]));
    // Lanes 2,3: input axes against element corners.
    rso_lane #(.CW(CW)) u_lane2 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_ax0_x(i_corner0_x), .i_ax0_y(i_corner0_y),
        .i_ax1_x(i_corner1_x), .i_ax1_y(i_corner1_y),
        .i_ox(w_ex), .i_oy(w_ey), .o_res(w_res[2]));
    rso_lane #(.CW(CW)) u_lane3 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_ax0_x(i_corner0_x), .i_ax0_y(i_corner0_y),
        .i_ax1_x(i_corner2_x), .i_ax1_y(i_corner2_y),
        .i_ox(w_ex), .i_oy(w_ey), .o_res(w_res[3]));

    rso_merge u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(r_s1_vld && w_adv), .i_pt(r_s1_pt), .i_res(w_res),
        .i_rdy(i_ready), .o_vld(o_valid), .o_hit(o_hit));

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit))
        else $error("result dropped under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stall with empty output");
    a_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_adv |=> r_s1_vld)
        else $error("stage 1 item lost");
`endif
endmodule
